[rtl/core/prr_pkg.sv]
package prr_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int TRIG_W = 18;
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 42;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int DIV_LAT = DIV_NW + 2;
  localparam int SOLVE_LAT = 5 + DIV_LAT;
  localparam int ACCEL_LAT = 5;

  localparam logic [1:0] REG_LINK2 = 2'd0;
  localparam logic [1:0] REG_LINK3 = 2'd1;
  localparam logic [1:0] REG_SING_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] s2;
    logic signed [TRIG_W-1:0] c23;
    logic signed [TRIG_W-1:0] s23;
    logic signed [TRIG_W-1:0] s3;
  } trig_t;

  function automatic logic signed [31:0] atan_turn(input int unsigned idx);
    logic signed [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/prr_delay.sv]
module prr_delay import prr_pkg::*; #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < D; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[D-1];

endmodule

[rtl/core/prr_cordic.sv]
module prr_cordic import prr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [15:0]              angle_i,
  output logic                     valid_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam int N = CORDIC_STEPS;

  logic signed [32:0] x_q [N+1];
  logic signed [32:0] y_q [N+1];
  logic signed [31:0] z_q [N+1];
  logic [1:0]         quad_q [N+1];
  logic [N+1:0]       vld_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  function automatic logic signed [TRIG_W-1:0] round_q16(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd8192) >>> 14;
    if (r > 33'sd65536) begin
      r = 33'sd65536;
    end else if (r < -33'sd65536) begin
      r = -33'sd65536;
    end
    return r[TRIG_W-1:0];
  endfunction

  logic [15:0] fold_sum, fold_rem;
  logic [1:0]  fold_quad;

  assign fold_sum  = angle_i + 16'h2000;
  assign fold_quad = fold_sum[15:14];
  assign fold_rem  = angle_i - {fold_quad, 14'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_START;
      y_q[0]    <= '0;
      z_q[0]    <= {fold_rem, 16'h0000};
      quad_q[0] <= fold_quad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][31]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
      end
    end
  end

  logic signed [TRIG_W-1:0] cr, sr;
  assign cr = round_q16(x_q[N]);
  assign sr = round_q16(y_q[N]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[N])
        2'd0: begin
          cos_q <= cr;
          sin_q <= sr;
        end
        2'd1: begin
          cos_q <= -sr;
          sin_q <= cr;
        end
        2'd2: begin
          cos_q <= -cr;
          sin_q <= -sr;
        end
        default: begin
          cos_q <= sr;
          sin_q <= -cr;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N:0], valid_i};
    end
  end

  assign valid_o = vld_q[N+1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

[rtl/core/prr_div.sv]
module prr_div import prr_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 valid_o,
  output logic signed [31:0]   quot_o
);

  localparam logic [NW-1:0] LIM_NEG = NW'(64'h80000000);
  localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFFFFFF);

  logic [NW-1:0] nq_q  [NW+1];
  logic [DW-1:0] r_q   [NW+1];
  logic [DW-1:0] d_q   [NW+1];
  logic          neg_q [NW+1];
  logic [NW+1:0] vld_q;
  logic signed [31:0] quot_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]  <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      d_q[0]   <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      r_q[0]   <= '0;
      neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [DW:0] trial;
    assign trial = {r_q[k], nq_q[k][NW-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        if (trial >= {1'b0, d_q[k]}) begin
          r_q[k+1]  <= DW'(trial - {1'b0, d_q[k]});
          nq_q[k+1] <= {nq_q[k][NW-2:0], 1'b1};
        end else begin
          r_q[k+1]  <= trial[DW-1:0];
          nq_q[k+1] <= {nq_q[k][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[NW]) begin
        quot_q <= (nq_q[NW] > LIM_NEG) ? 32'sh80000000 : -nq_q[NW][31:0];
      end else begin
        quot_q <= (nq_q[NW] > LIM_POS) ? 32'sh7FFFFFFF : nq_q[NW][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW:0], valid_i};
    end
  end

  assign valid_o = vld_q[NW+1];
  assign quot_o  = quot_q;

endmodule

[rtl/core/prr_solve.sv]
module prr_solve import prr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  trig_t              trig_i,
  input  logic [11:0]        a2_i,
  input  logic [11:0]        a3_i,
  output logic               valid_o,
  output logic signed [31:0] q2_o,
  output logic signed [31:0] q3_o
);

  logic [4:0] vld_q;

  logic signed [49:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [30:0] d2_q, d2b_q, d2c_q, d2e_q;
  logic [23:0]        a23_q;
  logic signed [TRIG_W-1:0] s3_q;

  logic signed [50:0] u_q, v_q, v3_q, v4_q;
  logic signed [42:0] d3_q, d3b_q, d3e_q;

  logic [36:0]        pa_lo_q, pb_lo_q;
  logic signed [38:0] pa_hi_q, pb_hi_q;

  logic signed [63:0] m1_q, m2_q;
  logic signed [63:0] num2_q, num3_q;
  logic signed [DIV_DW-1:0] den2_q, den3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= trig_i.s2 * by_i;
      p2_q  <= trig_i.c2 * bx_i;
      p3_q  <= trig_i.s23 * by_i;
      p4_q  <= trig_i.c23 * bx_i;
      d2_q  <= $signed({1'b0, a2_i}) * trig_i.s3;
      a23_q <= a2_i * a3_i;
      s3_q  <= trig_i.s3;

      u_q   <= 51'(p1_q) + 51'(p2_q);
      v_q   <= 51'(p3_q) + 51'(p4_q);
      d3_q  <= $signed({1'b0, a23_q}) * s3_q;
      d2b_q <= d2_q;

      pa_lo_q <= a2_i * u_q[24:0];
      pa_hi_q <= $signed({1'b0, a2_i}) * $signed(u_q[50:25]);
      pb_lo_q <= a3_i * v_q[24:0];
      pb_hi_q <= $signed({1'b0, a3_i}) * $signed(v_q[50:25]);
      v3_q    <= v_q;
      d2c_q   <= d2b_q;
      d3b_q   <= d3_q;

      m1_q  <= $signed({pa_hi_q, 25'b0}) + $signed({27'b0, pa_lo_q});
      m2_q  <= $signed({pb_hi_q, 25'b0}) + $signed({27'b0, pb_lo_q});
      v4_q  <= v3_q;
      d2e_q <= d2c_q;
      d3e_q <= d3b_q;

      num3_q <= -(m1_q + m2_q);
      num2_q <= 64'(v4_q);
      den2_q <= DIV_DW'(d2e_q);
      den3_q <= d3e_q[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  prr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[4]),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .valid_o (valid_o),
    .quot_o  (q2_o)
  );

  prr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[4]),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .valid_o (),
    .quot_o  (q3_o)
  );

endmodule

[rtl/core/prr_accel.sv]
module prr_accel import prr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] w2_i,
  input  logic signed [31:0] w3_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  trig_t              trig_i,
  input  logic [11:0]        a2_i,
  input  logic [11:0]        a3_i,
  output logic               valid_o,
  output logic signed [31:0] bx_o,
  output logic signed [31:0] by_o
);

  localparam int SQW = 64 - FRACTION_BITS;
  localparam int PW  = SQW + 29;
  localparam logic [PW-1:0] TERM_LIM = PW'(64'h10000000000);

  logic [ACCEL_LAT-1:0] vld_q;

  logic signed [31:0] w2_q, w23_q;
  logic signed [31:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q, ax4_q, ay4_q;
  logic [27:0]        kmag1_q [4];
  logic [27:0]        kmag2_q [4];
  logic               kneg1_q [4];
  logic               kneg2_q [4];
  logic               kneg3_q [4];
  logic [SQW-1:0]     sq2_q, sq23_q;
  logic [55:0]        plo_q [4];
  logic [SQW-1:0]     phi_q [4];
  logic signed [41:0] term_q [4];
  logic signed [31:0] bx_q, by_q;

  logic signed [30:0] k_d [4];
  logic signed [63:0] sq2_full, sq23_full;

  assign k_d[0] = $signed({1'b0, a2_i}) * trig_i.c2;
  assign k_d[1] = $signed({1'b0, a3_i}) * trig_i.c23;
  assign k_d[2] = $signed({1'b0, a2_i}) * trig_i.s2;
  assign k_d[3] = $signed({1'b0, a3_i}) * trig_i.s23;

  assign sq2_full  = w2_q * w2_q;
  assign sq23_full = w23_q * w23_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w2_q  <= w2_i;
      w23_q <= sat32(64'(w2_i) + 64'(w3_i));
      ax1_q <= ax_i;
      ay1_q <= ay_i;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
      ax4_q <= ax3_q;
      ay4_q <= ay3_q;
      sq2_q  <= sq2_full[63:FRACTION_BITS];
      sq23_q <= sq23_full[63:FRACTION_BITS];
      bx_q <= sat32(64'(ax4_q) + 64'(term_q[0]) + 64'(term_q[1]));
      by_q <= sat32(64'(ay4_q) + 64'(term_q[2]) + 64'(term_q[3]));
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_term
    logic [SQW-1:0] sq;
    logic [PW-1:0]  prod, shifted;
    logic [40:0]    mag;
    assign sq      = (j % 2 == 1) ? sq23_q : sq2_q;
    assign prod    = {1'b0, phi_q[j], 28'b0} + PW'(plo_q[j]);
    assign shifted = prod >> 16;
    assign mag     = (shifted > TERM_LIM) ? 41'h10000000000 : shifted[40:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kmag1_q[j] <= k_d[j][30] ? 28'(-k_d[j]) : k_d[j][27:0];
        kneg1_q[j] <= k_d[j][30];
        kmag2_q[j] <= kmag1_q[j];
        kneg2_q[j] <= kneg1_q[j];
        plo_q[j]   <= kmag2_q[j] * sq[27:0];
        phi_q[j]   <= SQW'(kmag2_q[j] * sq[SQW-1:28]);
        kneg3_q[j] <= kneg2_q[j];
        term_q[j]  <= kneg3_q[j] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ACCEL_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[ACCEL_LAT-1];
  assign bx_o    = bx_q;
  assign by_o    = by_q;

endmodule

[rtl/core/prr_arm_joint_rate_resolver.sv]
// Joint rate resolver for a slide plus two revolute links.
// The input channel carries two joint angles and the end point velocity and
// acceleration; the output channel carries the slide, joint2 and joint3 rates
// and accelerations and a singular flag. Both channels use valid and ready.
// The configuration port writes the two link lengths and the singular limit
// and must be written only while no transfer is in flight.
// While the output is not stalled, every cycle the block can take a new item,
// so the sustained rate is one item per cycle. An item passes through the
// CORDIC stages, the velocity solve, the centripetal terms, the acceleration
// solve (each solve is five multiply and add stages then a 64 stage restoring
// divider) and one output register.
// The whole pipeline advances together. When the output is valid and the
// receiver holds ready low, every stage holds and in_ready_o drops, so no item
// is lost or repeated.
// Reset clears all valid bits and loads the register defaults: link lengths
// 300 and 200, singular limit 66.
module prr_arm_joint_rate_resolver import prr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        theta2_i,
  input  logic [15:0]        theta3_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] slide_rate_o,
  output logic signed [31:0] joint2_rate_o,
  output logic signed [31:0] joint3_rate_o,
  output logic signed [31:0] slide_accel_o,
  output logic signed [31:0] joint2_accel_o,
  output logic signed [31:0] joint3_accel_o,
  output logic               singular_o
);

  localparam int CL = CORDIC_LAT;
  localparam int SL = SOLVE_LAT;
  localparam int AL = ACCEL_LAT;

  logic [11:0] link2_length_q, link3_length_q;
  logic [15:0] singular_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link2_length_q   <= 12'd300;
      link3_length_q   <= 12'd200;
      singular_limit_q <= 16'd66;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINK2:      link2_length_q   <= cfg_data_i[11:0];
        REG_LINK3:      link3_length_q   <= cfg_data_i[11:0];
        REG_SING_LIMIT: singular_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  logic pipe_en;

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  logic [15:0] theta23;
  assign theta23 = theta2_i + theta3_i;

  logic cordic_valid;
  trig_t trig0, trig1, trig2;

  prr_cordic u_cordic2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .angle_i (theta2_i),
    .valid_o (cordic_valid),
    .cos_o   (trig0.c2),
    .sin_o   (trig0.s2)
  );

  prr_cordic u_cordic3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .angle_i (theta3_i),
    .valid_o (),
    .cos_o   (),
    .sin_o   (trig0.s3)
  );

  prr_cordic u_cordic23 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .angle_i (theta23),
    .valid_o (),
    .cos_o   (trig0.c23),
    .sin_o   (trig0.s23)
  );

  logic [63:0] vxy_dly, axy_dly, vaz_dly, w_dly;
  logic        sing_dly;

  prr_delay #(.W(64), .D(CL)) u_dly_vxy (
    .clk_i (clk_i), .en_i (pipe_en), .data_i ({vel_x_i, vel_y_i}), .data_o (vxy_dly)
  );

  prr_delay #(.W(64), .D(CL + SL)) u_dly_axy (
    .clk_i (clk_i), .en_i (pipe_en), .data_i ({acc_x_i, acc_y_i}), .data_o (axy_dly)
  );

  prr_delay #(.W(64), .D(CL + 2 * SL + AL)) u_dly_vaz (
    .clk_i (clk_i), .en_i (pipe_en), .data_i ({vel_z_i, acc_z_i}), .data_o (vaz_dly)
  );

  logic [TRIG_W-2:0] mag3;
  logic              sing;

  assign mag3 = trig0.s3[TRIG_W-1] ? (TRIG_W-1)'(-trig0.s3) : trig0.s3[TRIG_W-2:0];
  assign sing = (link2_length_q == '0) || (link3_length_q == '0) || (trig0.s3 == '0) ||
                (mag3 < (TRIG_W-1)'(singular_limit_q));

  prr_delay #(.W(1), .D(2 * SL + AL)) u_dly_sing (
    .clk_i (clk_i), .en_i (pipe_en), .data_i (sing), .data_o (sing_dly)
  );

  prr_delay #(.W($bits(trig_t)), .D(SL)) u_dly_trig1 (
    .clk_i (clk_i), .en_i (pipe_en), .data_i (trig0), .data_o (trig1)
  );

  prr_delay #(.W($bits(trig_t)), .D(AL)) u_dly_trig2 (
    .clk_i (clk_i), .en_i (pipe_en), .data_i (trig1), .data_o (trig2)
  );

  logic               vel_valid, acc_in_valid, acc_valid;
  logic signed [31:0] w2, w3, bx, by, e2, e3;

  prr_solve u_solve_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (cordic_valid),
    .bx_i    (vxy_dly[63:32]),
    .by_i    (vxy_dly[31:0]),
    .trig_i  (trig0),
    .a2_i    (link2_length_q),
    .a3_i    (link3_length_q),
    .valid_o (vel_valid),
    .q2_o    (w2),
    .q3_o    (w3)
  );

  prr_delay #(.W(64), .D(AL + SL)) u_dly_w (
    .clk_i (clk_i), .en_i (pipe_en), .data_i ({w2, w3}), .data_o (w_dly)
  );

  prr_accel #(.FRACTION_BITS(FRACTION_BITS)) u_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vel_valid),
    .w2_i    (w2),
    .w3_i    (w3),
    .ax_i    (axy_dly[63:32]),
    .ay_i    (axy_dly[31:0]),
    .trig_i  (trig1),
    .a2_i    (link2_length_q),
    .a3_i    (link3_length_q),
    .valid_o (acc_in_valid),
    .bx_o    (bx),
    .by_o    (by)
  );

  prr_solve u_solve_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (acc_in_valid),
    .bx_i    (bx),
    .by_i    (by),
    .trig_i  (trig2),
    .a2_i    (link2_length_q),
    .a3_i    (link3_length_q),
    .valid_o (acc_valid),
    .q2_o    (e2),
    .q3_o    (e3)
  );

  logic signed [31:0] slide_rate_q, joint2_rate_q, joint3_rate_q;
  logic signed [31:0] slide_accel_q, joint2_accel_q, joint3_accel_q;
  logic               singular_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      slide_rate_q   <= vaz_dly[63:32];
      slide_accel_q  <= vaz_dly[31:0];
      singular_q     <= sing_dly;
      joint2_rate_q  <= sing_dly ? '0 : w_dly[63:32];
      joint3_rate_q  <= sing_dly ? '0 : w_dly[31:0];
      joint2_accel_q <= sing_dly ? '0 : e2;
      joint3_accel_q <= sing_dly ? '0 : e3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= acc_valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slide_rate_o   = slide_rate_q;
  assign joint2_rate_o  = joint2_rate_q;
  assign joint3_rate_o  = joint3_rate_q;
  assign slide_accel_o  = slide_accel_q;
  assign joint2_accel_o = joint2_accel_q;
  assign joint3_accel_o = joint3_accel_q;
  assign singular_o     = singular_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> joint2_rate_o == '0 && joint3_rate_o == '0 &&
    joint2_accel_o == '0 && joint3_accel_o == '0)
    else $error("singular result carries nonzero joint values");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(joint3_accel_o) && $stable(singular_o))
    else $error("result changed while stalled");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import prr_pkg::*;

  localparam int LATENCY = 170;
  localparam int STALL_LIMIT = 5000;
  localparam longint TERM_CAP = 64'sd1 << 40;
  localparam longint ATAN_TURNS [20] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
    'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518};

  typedef struct packed {
    logic [15:0] theta2;
    logic [15:0] theta3;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slide_rate;
    logic signed [31:0] joint2_rate;
    logic signed [31:0] joint3_rate;
    logic signed [31:0] slide_accel;
    logic signed [31:0] joint2_accel;
    logic signed [31:0] joint3_accel;
    logic singular;
  } rates_t;

  class joint_rate_board;
    longint link2 = 300;
    longint link3 = 200;
    longint sing_limit = 66;
    rates_t pending_rates[$];
    int errors = 0;

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_LINK2) begin
        link2 = data[11:0];
      end else if (idx == REG_LINK3) begin
        link3 = data[11:0];
      end else if (idx == REG_SING_LIMIT) begin
        sing_limit = data;
      end
    endfunction

    function longint sat(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function longint to_q16(longint v);
      longint r;
      r = (v + 8192) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r;
    endfunction

    function void sin_cos(logic [15:0] ang, output longint c, output longint s);
      int unsigned a, quad;
      longint rem, x, y, z, dx, dy, cr, sr;
      a = ang;
      quad = ((a + 32'h2000) >> 14) & 3;
      rem = longint'((a - quad * 32'h4000) & 32'hFFFF);
      if (rem >= 'h8000) rem -= 'h10000;
      z = rem * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURNS[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TURNS[i];
        end
      end
      cr = to_q16(x);
      sr = to_q16(y);
      case (quad)
        0: begin c = cr; s = sr; end
        1: begin c = -sr; s = cr; end
        2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endfunction

    function longint centripetal(longint k, longint w);
      longint unsigned sq, mag, prod;
      longint p;
      sq = longint'(w * w) >> 16;
      mag = k < 0 ? -k : k;
      if (mag == 0) return 0;
      if (sq > 64'h7FFFFFFFFFFFFFFF / mag) begin
        p = TERM_CAP;
      end else begin
        prod = (mag * sq) >> 16;
        p = prod > TERM_CAP ? TERM_CAP : longint'(prod);
      end
      return k < 0 ? -p : p;
    endfunction

    function void note_point(point_t pt);
      longint c2, s2, c3, s3, c23, s23, w2, w3, e2, e3, d2, d3, w23, bx, by, m3;
      logic [15:0] t23;
      rates_t r;
      bit sing;
      t23 = pt.theta2 + pt.theta3;
      sin_cos(pt.theta2, c2, s2);
      sin_cos(pt.theta3, c3, s3);
      sin_cos(t23, c23, s23);
      m3 = s3 < 0 ? -s3 : s3;
      sing = link2 == 0 || link3 == 0 || s3 == 0 || m3 < sing_limit;
      w2 = 0; w3 = 0; e2 = 0; e3 = 0;
      if (!sing) begin
        d2 = link2 * s3;
        d3 = link2 * link3 * s3;
        w2 = sat((pt.vel_x * c23 + pt.vel_y * s23) / d2);
        w3 = sat(-(link2 * (s2 * pt.vel_y + c2 * pt.vel_x)
                   + link3 * (s23 * pt.vel_y + c23 * pt.vel_x)) / d3);
        w23 = sat(w2 + w3);
        bx = sat(pt.acc_x + centripetal(link2 * c2, w2) + centripetal(link3 * c23, w23));
        by = sat(pt.acc_y + centripetal(link2 * s2, w2) + centripetal(link3 * s23, w23));
        e2 = sat((bx * c23 + by * s23) / d2);
        e3 = sat(-(link2 * (s2 * by + c2 * bx) + link3 * (s23 * by + c23 * bx)) / d3);
      end
      r.slide_rate = pt.vel_z;
      r.joint2_rate = w2;
      r.joint3_rate = w3;
      r.slide_accel = pt.acc_z;
      r.joint2_accel = e2;
      r.joint3_accel = e3;
      r.singular = sing;
      pending_rates.push_back(r);
    endfunction

    function void field(string name, longint exp, longint act);
      if (exp != act) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_rates(rates_t act);
      rates_t e;
      if (pending_rates.size() == 0) begin
        errors++;
        $display("%0t unexpected result transfer", $time);
        return;
      end
      e = pending_rates.pop_front();
      field("slide_rate", e.slide_rate, act.slide_rate);
      field("joint2_rate", e.joint2_rate, act.joint2_rate);
      field("joint3_rate", e.joint3_rate, act.joint3_rate);
      field("slide_accel", e.slide_accel, act.slide_accel);
      field("joint2_accel", e.joint2_accel, act.joint2_accel);
      field("joint3_accel", e.joint3_accel, act.joint3_accel);
      field("singular", e.singular, act.singular);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  point_t pt_drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rates_t res;

  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  joint_rate_board board = new();

  prr_arm_joint_rate_resolver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .theta2_i(pt_drv.theta2), .theta3_i(pt_drv.theta3),
    .vel_x_i(pt_drv.vel_x), .vel_y_i(pt_drv.vel_y), .vel_z_i(pt_drv.vel_z),
    .acc_x_i(pt_drv.acc_x), .acc_y_i(pt_drv.acc_y), .acc_z_i(pt_drv.acc_z),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .slide_rate_o(res.slide_rate), .joint2_rate_o(res.joint2_rate),
    .joint3_rate_o(res.joint3_rate), .slide_accel_o(res.slide_accel),
    .joint2_accel_o(res.joint2_accel), .joint3_accel_o(res.joint3_accel),
    .singular_o(res.singular)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_rates(res);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    out_ready_i <= $urandom_range(99) >= recv_stall;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic cfg_end();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(point_t pt);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pt_drv <= pt;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_point(pt);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_rates.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
  endtask

  function automatic point_t random_point();
    point_t pt;
    pt.theta2 = 16'($urandom);
    pt.theta3 = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      pt.theta3 = 16'(($urandom_range(1) ? 16'h8000 : 16'h0000) + $urandom_range(160) - 80);
    end
    {pt.vel_x, pt.vel_y, pt.vel_z} = {$urandom, $urandom, $urandom};
    {pt.acc_x, pt.acc_y, pt.acc_z} = {$urandom, $urandom, $urandom};
    if ($urandom_range(2) != 0) begin
      pt.vel_x = $signed(pt.vel_x) >>> $urandom_range(31, 8);
      pt.vel_y = $signed(pt.vel_y) >>> $urandom_range(31, 8);
      pt.acc_x = $signed(pt.acc_x) >>> $urandom_range(31, 8);
      pt.acc_y = $signed(pt.acc_y) >>> $urandom_range(31, 8);
    end
    return pt;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_point(random_point());
    end
  endtask

  initial begin
    logic [15:0] angles [12];
    point_t pt;
    angles = '{16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h4000,
      16'h6000, 16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF, 16'h0034};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 12; i++) begin
      pt.theta2 = angles[(i * 5) % 12];
      pt.theta3 = angles[i];
      pt.vel_x = i[0] ? 32'sh7FFFFFFF : -32'sh80000000;
      pt.vel_y = i[1] ? -32'sh80000000 : 32'sh7FFFFFFF;
      pt.vel_z = i[0] ? 32'sh7FFFFFFF : -32'sh80000000;
      pt.acc_x = i[2] ? 32'sh7FFFFFFF : 32'sh00010000;
      pt.acc_y = i[0] ? -32'sh80000000 : 32'sh0;
      pt.acc_z = i[1] ? 32'sh7FFFFFFF : -32'sh80000000;
      send_point(pt);
      pt.vel_x = 32'sh0001_0000; pt.vel_y = -32'sh0002_8000; pt.vel_z = 0;
      pt.acc_x = 0; pt.acc_y = 32'sh0000_4000; pt.acc_z = 0;
      send_point(pt);
    end
    run_random(300);
    drain();

    cfg_write(REG_LINK2, 16'hFFFF);
    cfg_write(REG_LINK3, 16'h0FFF);
    cfg_write(REG_SING_LIMIT, 16'h0000);
    cfg_end();
    send_idle = 77;
    run_random(300);
    drain();

    cfg_write(REG_LINK2, 16'h0001);
    cfg_write(REG_LINK3, 16'h0001);
    cfg_write(REG_SING_LIMIT, 16'hFFFF);
    cfg_end();
    send_idle = 0;
    recv_stall = 77;
    run_random(150);
    drain();

    cfg_write(REG_LINK2, 16'd123);
    cfg_write(REG_LINK3, 16'd3000);
    cfg_write(REG_SING_LIMIT, 16'd1000);
    cfg_write(2'd3, 16'hFFFF);
    cfg_end();
    send_idle = 38;
    recv_stall = 38;
    run_random(400);
    drain();

    cfg_write(REG_LINK2, 16'h1000);
    cfg_end();
    send_idle = 0;
    recv_stall = 0;
    run_random(100);
    drain();

    cfg_write(REG_LINK2, 16'($urandom_range(4095, 1)));
    cfg_write(REG_LINK3, 16'($urandom_range(4095, 1)));
    cfg_write(REG_SING_LIMIT, 16'($urandom_range(4000)));
    cfg_end();
    send_idle = 38;
    recv_stall = 77;
    run_random(276);
    drain();

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[prr_arm_joint_rate_resolver.f]
rtl/core/prr_pkg.sv
rtl/core/prr_delay.sv
rtl/core/prr_cordic.sv
rtl/core/prr_div.sv
rtl/core/prr_solve.sv
rtl/core/prr_accel.sv
rtl/core/prr_arm_joint_rate_resolver.sv
bench/testbench.sv
